// ----- sv/bicubic_sample_four_channel_top_macros.svh -----
// assertion helpers shared by the sampler modules
// every macro expects clk and arst_n in scope
`ifndef BICUBIC_SAMPLE_FOUR_CHANNEL_TOP_MACROS_SVH
`define BICUBIC_SAMPLE_FOUR_CHANNEL_TOP_MACROS_SVH

// property must hold at every edge out of reset
`define BICUB4_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true out of reset
`define BICUB4_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

// a rise of sig must be caused by cause at the earlier edge that the depth n selects
`define BICUB4_ROSE_AFTER(lbl, sig, cause, n, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		$rose(sig) |-> $past(cause, n)) else $error(msg);

`endif

// ----- sv/bicub4_pkg.sv -----
`timescale 1ns / 1ps

package bicub4_pkg;

	localparam int SRC_DEPTH = 1024;
	localparam int ADDR_W    = $clog2(SRC_DEPTH);
	localparam int IDX_W     = 10;
	localparam int NUM_CH    = 4;
	localparam int CH_W      = 16;
	localparam int PIX_W     = NUM_CH * CH_W;
	localparam int FRAC_W    = 16;
	localparam int TS_W      = FRAC_W + 1;
	localparam int COEF_W    = 21;
	localparam int H1_W      = COEF_W + TS_W;
	localparam int H2_W      = H1_W + TS_W;
	localparam int P_W       = H2_W + TS_W;
	localparam int FRAC_SH   = 3 * FRAC_W + 2;
	localparam int Q_W       = P_W - FRAC_SH;
	localparam int R_W       = Q_W + 1;

	// cycles from sample accept edge to the edge at which out_valid first reads high
	localparam int RESULT_LAT = 9;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic signed [CH_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [CH_W-1:0] SAT_MIN = 16'sh8000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_B,
		ST_RD_C,
		ST_RD_D,
		ST_COEF,
		ST_HORN1,
		ST_HORN2,
		ST_HORN3,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		SEL_A,
		SEL_B,
		SEL_C,
		SEL_D
	} sel_t;

	typedef struct packed {
		logic mem_we;
		logic mem_re;
		sel_t rd_sel;
		logic cap_sample;
		logic lat_a;
		logic lat_b;
		logic lat_c;
		logic coef_en;
		logic h1_en;
		logic h2_en;
		logic h3_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ----- sv/bicub4_ctrl.sv -----
`timescale 1ns / 1ps

`include "bicubic_sample_four_channel_top_macros.svh"

module bicub4_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              op,
	output logic              in_stall,
	output bicub4_pkg::cmd_t  cmd,
	input  bicub4_pkg::sts_t  sts
);

	bicub4_pkg::state_t state_q;
	bicub4_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bicub4_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bicub4_pkg::ST_IDLE: begin
				if (in_valid && (op == bicub4_pkg::OP_SAMPLE)) begin
					state_d = bicub4_pkg::ST_RD_B;
				end
			end
			bicub4_pkg::ST_RD_B:  state_d = bicub4_pkg::ST_RD_C;
			bicub4_pkg::ST_RD_C:  state_d = bicub4_pkg::ST_RD_D;
			bicub4_pkg::ST_RD_D:  state_d = bicub4_pkg::ST_COEF;
			bicub4_pkg::ST_COEF:  state_d = bicub4_pkg::ST_HORN1;
			bicub4_pkg::ST_HORN1: state_d = bicub4_pkg::ST_HORN2;
			bicub4_pkg::ST_HORN2: state_d = bicub4_pkg::ST_HORN3;
			bicub4_pkg::ST_HORN3: state_d = bicub4_pkg::ST_FIN;
			bicub4_pkg::ST_FIN: begin
				if (sts.out_free) begin
					state_d = bicub4_pkg::ST_IDLE;
				end
			end
			default: state_d = bicub4_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = bicub4_pkg::SEL_A;
		in_stall = 1'b1;
		unique case (state_q)
			bicub4_pkg::ST_IDLE: begin
				in_stall       = 1'b0;
				cmd.mem_we     = in_valid && (op == bicub4_pkg::OP_LOAD);
				cmd.mem_re     = in_valid && (op == bicub4_pkg::OP_SAMPLE);
				cmd.cap_sample = in_valid && (op == bicub4_pkg::OP_SAMPLE);
			end
			bicub4_pkg::ST_RD_B: begin
				cmd.mem_re = 1'b1;
				cmd.rd_sel = bicub4_pkg::SEL_B;
				cmd.lat_a  = 1'b1;
			end
			bicub4_pkg::ST_RD_C: begin
				cmd.mem_re = 1'b1;
				cmd.rd_sel = bicub4_pkg::SEL_C;
				cmd.lat_b  = 1'b1;
			end
			bicub4_pkg::ST_RD_D: begin
				cmd.mem_re = 1'b1;
				cmd.rd_sel = bicub4_pkg::SEL_D;
				cmd.lat_c  = 1'b1;
			end
			bicub4_pkg::ST_COEF:  cmd.coef_en = 1'b1;
			bicub4_pkg::ST_HORN1: cmd.h1_en   = 1'b1;
			bicub4_pkg::ST_HORN2: cmd.h2_en   = 1'b1;
			bicub4_pkg::ST_HORN3: cmd.h3_en   = 1'b1;
			bicub4_pkg::ST_FIN:   cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	`BICUB4_NEVER(a_port_conflict, cmd.mem_we && cmd.mem_re, "store written and read together")
	`BICUB4_ASSERT(a_sample_starts, (state_q == bicub4_pkg::ST_IDLE) && in_valid && (op == bicub4_pkg::OP_SAMPLE) |=> (state_q == bicub4_pkg::ST_RD_B), "sample accept did not start reads")
	`BICUB4_ASSERT(a_fin_waits, (state_q == bicub4_pkg::ST_FIN) && !sts.out_free |=> (state_q == bicub4_pkg::ST_FIN), "left final step with output still full")

endmodule

// ----- sv/bicub4_dp.sv -----
`timescale 1ns / 1ps

module bicub4_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bicub4_pkg::cmd_t                      cmd,
	output bicub4_pkg::sts_t                      sts,
	input  logic [bicub4_pkg::IDX_W-1:0]          load_index,
	input  logic signed [bicub4_pkg::CH_W-1:0]    load_ch0,
	input  logic signed [bicub4_pkg::CH_W-1:0]    load_ch1,
	input  logic signed [bicub4_pkg::CH_W-1:0]    load_ch2,
	input  logic signed [bicub4_pkg::CH_W-1:0]    load_ch3,
	input  logic [bicub4_pkg::IDX_W-1:0]          pos_a,
	input  logic [bicub4_pkg::IDX_W-1:0]          pos_b,
	input  logic [bicub4_pkg::IDX_W-1:0]          pos_c,
	input  logic [bicub4_pkg::IDX_W-1:0]          pos_d,
	input  logic [bicub4_pkg::FRAC_W-1:0]         frac,
	input  logic                                  last_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [bicub4_pkg::CH_W-1:0]    res_ch0,
	output logic signed [bicub4_pkg::CH_W-1:0]    res_ch1,
	output logic signed [bicub4_pkg::CH_W-1:0]    res_ch2,
	output logic signed [bicub4_pkg::CH_W-1:0]    res_ch3,
	output logic                                  clipped,
	output logic                                  last_out
);

	// pixel store, undefined until loaded
	logic [bicub4_pkg::PIX_W-1:0] mem [bicub4_pkg::SRC_DEPTH];

	logic [bicub4_pkg::IDX_W-1:0] pos_b_q, pos_c_q, pos_d_q;
	logic [bicub4_pkg::FRAC_W-1:0] frac_q;
	logic                          last_q;

	logic [bicub4_pkg::IDX_W-1:0] mem_addr;
	logic                          addr_ok;
	logic [bicub4_pkg::PIX_W-1:0] wr_word;
	logic [bicub4_pkg::PIX_W-1:0] rd_q;
	logic                          rd_zero_q;
	logic [bicub4_pkg::PIX_W-1:0] rd_word;
	logic [bicub4_pkg::PIX_W-1:0] pix_a_q, pix_b_q, pix_c_q;

	logic signed [bicub4_pkg::TS_W-1:0] t_s;

	logic                                out_valid_q;
	logic signed [bicub4_pkg::CH_W-1:0] res_q [bicub4_pkg::NUM_CH];
	logic signed [bicub4_pkg::CH_W-1:0] res_d [bicub4_pkg::NUM_CH];
	logic [bicub4_pkg::NUM_CH-1:0]      clip_d;
	logic                                clipped_q;
	logic                                last_out_q;

	always_comb begin
		mem_addr = load_index;
		if (!cmd.mem_we) begin
			unique case (cmd.rd_sel)
				bicub4_pkg::SEL_A: mem_addr = pos_a;
				bicub4_pkg::SEL_B: mem_addr = pos_b_q;
				bicub4_pkg::SEL_C: mem_addr = pos_c_q;
				bicub4_pkg::SEL_D: mem_addr = pos_d_q;
				default:           mem_addr = pos_a;
			endcase
		end
	end

	assign addr_ok = (32'(mem_addr) < 32'(bicub4_pkg::SRC_DEPTH));
	assign wr_word = {load_ch3, load_ch2, load_ch1, load_ch0};

	always_ff @(posedge clk) begin
		if (cmd.mem_we && addr_ok) begin
			mem[bicub4_pkg::ADDR_W'(mem_addr)] <= wr_word;
		end
		if (cmd.mem_re) begin
			rd_q      <= mem[bicub4_pkg::ADDR_W'(mem_addr)];
			rd_zero_q <= !addr_ok;
		end
	end

	// out-of-range neighbours read as zero
	assign rd_word = rd_zero_q ? '0 : rd_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_sample) begin
			pos_b_q <= pos_b;
			pos_c_q <= pos_c;
			pos_d_q <= pos_d;
			frac_q  <= frac;
			last_q  <= last_in;
		end
		if (cmd.lat_a) pix_a_q <= rd_word;
		if (cmd.lat_b) pix_b_q <= rd_word;
		if (cmd.lat_c) pix_c_q <= rd_word;
	end

	assign t_s = $signed({1'b0, frac_q});

	for (genvar ch = 0; ch < bicub4_pkg::NUM_CH; ch++) begin : g_lane
		logic signed [bicub4_pkg::CH_W-1:0]   va, vb, vc, vd;
		logic signed [bicub4_pkg::COEF_W-1:0] ea, eb, ec, ed;
		logic signed [bicub4_pkg::COEF_W-1:0] dbc, dda, sac, dca;
		logic signed [bicub4_pkg::COEF_W-1:0] a4_d, b4_d, c4_d;
		logic signed [bicub4_pkg::COEF_W-1:0] a4_q, b4_q, c4_q;
		logic signed [bicub4_pkg::H1_W-1:0]   prod1, h1_d, h1_q;
		logic signed [bicub4_pkg::H2_W-1:0]   prod2, h2_d, h2_q;
		logic signed [bicub4_pkg::P_W-1:0]    p_q, rnd;
		logic signed [bicub4_pkg::R_W-1:0]    sum;

		assign va = $signed(pix_a_q[ch*bicub4_pkg::CH_W +: bicub4_pkg::CH_W]);
		assign vb = $signed(pix_b_q[ch*bicub4_pkg::CH_W +: bicub4_pkg::CH_W]);
		assign vc = $signed(pix_c_q[ch*bicub4_pkg::CH_W +: bicub4_pkg::CH_W]);
		assign vd = $signed(rd_word[ch*bicub4_pkg::CH_W +: bicub4_pkg::CH_W]);

		assign ea = bicub4_pkg::COEF_W'(va);
		assign eb = bicub4_pkg::COEF_W'(vb);
		assign ec = bicub4_pkg::COEF_W'(vc);
		assign ed = bicub4_pkg::COEF_W'(vd);

		// coefficients times four: shift-add forms of 3, 5, 6 and 9
		assign dbc  = eb - ec;
		assign dda  = ed - ea;
		assign sac  = ea + ec;
		assign dca  = ec - ea;
		assign a4_d = (dbc <<< 2) + dbc + (dda <<< 1) + dda;
		assign b4_d = (sac <<< 2) + (sac <<< 1) - ((eb <<< 3) + eb) - ((ed <<< 1) + ed);
		assign c4_d = (dca <<< 1) + dca;

		// horner steps, scaled so the full sum sits over 2^50
		assign prod1 = a4_q * t_s;
		assign h1_d  = prod1 + (bicub4_pkg::H1_W'(b4_q) <<< bicub4_pkg::FRAC_W);
		assign prod2 = h1_q * t_s;
		assign h2_d  = prod2 + (bicub4_pkg::H2_W'(c4_q) <<< (2 * bicub4_pkg::FRAC_W));

		always_ff @(posedge clk) begin
			if (cmd.coef_en) begin
				a4_q <= a4_d;
				b4_q <= b4_d;
				c4_q <= c4_d;
			end
			if (cmd.h1_en) h1_q <= h1_d;
			if (cmd.h2_en) h2_q <= h2_d;
			if (cmd.h3_en) p_q  <= h2_q * t_s;
		end

		// round half up, add base sample, saturate
		assign rnd = p_q + (bicub4_pkg::P_W'(1) <<< (bicub4_pkg::FRAC_SH - 1));
		assign sum = bicub4_pkg::R_W'(vb)
			+ bicub4_pkg::R_W'($signed(rnd[bicub4_pkg::P_W-1:bicub4_pkg::FRAC_SH]));

		always_comb begin
			res_d[ch]  = sum[bicub4_pkg::CH_W-1:0];
			clip_d[ch] = 1'b0;
			if (sum > bicub4_pkg::R_W'(bicub4_pkg::SAT_MAX)) begin
				res_d[ch]  = bicub4_pkg::SAT_MAX;
				clip_d[ch] = 1'b1;
			end else if (sum < bicub4_pkg::R_W'(bicub4_pkg::SAT_MIN)) begin
				res_d[ch]  = bicub4_pkg::SAT_MIN;
				clip_d[ch] = 1'b1;
			end
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q      <= res_d;
			clipped_q  <= |clip_d;
			last_out_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign res_ch0   = res_q[0];
	assign res_ch1   = res_q[1];
	assign res_ch2   = res_q[2];
	assign res_ch3   = res_q[3];
	assign clipped   = clipped_q;
	assign last_out  = last_out_q;

endmodule

// ----- sv/bicubic_sample_four_channel_top.sv -----
// channel   direction   handshake            payload
// in        to block    in_valid / in_stall  op, load_index, load_ch0..3, pos_a..d, frac, last_in
// out       from block  out_valid/out_stall  res_ch0..3, clipped, last_out
//
// a load beat writes the pixel store at its accept edge and leaves the block ready for the next beat
// a sample beat runs through its steps before the next accept: four store reads on the single port,
//   one coefficient step, three horner multiply steps, one round and saturate step
// the result is loaded into the output register, and shows on out_valid, once the output is free
// a stalled output holds the last step until the register frees; in_stall stays high meanwhile
// reset clears control only; store contents are undefined until loaded
`timescale 1ns / 1ps

`include "bicubic_sample_four_channel_top_macros.svh"

module bicubic_sample_four_channel_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  op,
	input  logic [bicub4_pkg::IDX_W-1:0]          load_index,
	input  logic signed [bicub4_pkg::CH_W-1:0]    load_ch0,
	input  logic signed [bicub4_pkg::CH_W-1:0]    load_ch1,
	input  logic signed [bicub4_pkg::CH_W-1:0]    load_ch2,
	input  logic signed [bicub4_pkg::CH_W-1:0]    load_ch3,
	input  logic [bicub4_pkg::IDX_W-1:0]          pos_a,
	input  logic [bicub4_pkg::IDX_W-1:0]          pos_b,
	input  logic [bicub4_pkg::IDX_W-1:0]          pos_c,
	input  logic [bicub4_pkg::IDX_W-1:0]          pos_d,
	input  logic [bicub4_pkg::FRAC_W-1:0]         frac,
	input  logic                                  last_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [bicub4_pkg::CH_W-1:0]    res_ch0,
	output logic signed [bicub4_pkg::CH_W-1:0]    res_ch1,
	output logic signed [bicub4_pkg::CH_W-1:0]    res_ch2,
	output logic signed [bicub4_pkg::CH_W-1:0]    res_ch3,
	output logic                                  clipped,
	output logic                                  last_out
);

	// command and status between sequencer and datapath
	bicub4_pkg::cmd_t cmd;
	bicub4_pkg::sts_t sts;

	// sequencer: accepts beats, walks reads and arithmetic steps
	bicub4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: pixel store, four channel lanes, output register
	bicub4_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.load_index (load_index),
		.load_ch0   (load_ch0),
		.load_ch1   (load_ch1),
		.load_ch2   (load_ch2),
		.load_ch3   (load_ch3),
		.pos_a      (pos_a),
		.pos_b      (pos_b),
		.pos_c      (pos_c),
		.pos_d      (pos_d),
		.frac       (frac),
		.last_in    (last_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res_ch0    (res_ch0),
		.res_ch1    (res_ch1),
		.res_ch2    (res_ch2),
		.res_ch3    (res_ch3),
		.clipped    (clipped),
		.last_out   (last_out)
	);

	// checks on the ports
	logic sample_acc;
	logic any_rail;

	assign sample_acc = in_valid && !in_stall && (op == bicub4_pkg::OP_SAMPLE);

	// a clipped beat must carry at least one channel on a rail
	assign any_rail = (res_ch0 == bicub4_pkg::SAT_MAX) || (res_ch0 == bicub4_pkg::SAT_MIN)
		|| (res_ch1 == bicub4_pkg::SAT_MAX) || (res_ch1 == bicub4_pkg::SAT_MIN)
		|| (res_ch2 == bicub4_pkg::SAT_MAX) || (res_ch2 == bicub4_pkg::SAT_MIN)
		|| (res_ch3 == bicub4_pkg::SAT_MAX) || (res_ch3 == bicub4_pkg::SAT_MIN);

	`BICUB4_ASSERT(a_clip_rail, out_valid && clipped |-> any_rail, "clipped beat without railed channel")
	`BICUB4_ROSE_AFTER(a_result_latency, out_valid, sample_acc, bicub4_pkg::RESULT_LAT, "result without matching sample beat")

endmodule

// ----- bench/bicubic_sample_four_channel_top_tb.sv -----
`timescale 1ns / 1ps

module bicubic_sample_four_channel_top_tb;

	import bicub4_pkg::*;

	// random part size, receiver hold-off, and the no-progress limit
	// the limit covers the hold-off, the longest sender gap and a full sample
	localparam int RAND_ITEMS  = 1630;
	localparam int HOLD_CYCLES = 250;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PRINT_CAP   = 50;

	// one input beat as it sits on the ports; pos[0..3] are neighbours a..d
	typedef struct packed {
		logic                        op;
		logic [IDX_W-1:0]            load_index;
		logic [NUM_CH-1:0][CH_W-1:0] load_ch;
		logic [3:0][IDX_W-1:0]       pos;
		logic [FRAC_W-1:0]           frac;
		logic                        last;
	} beat_t;

	// one output beat, laid out to match {res_ch3..res_ch0, clipped, last_out}
	typedef struct packed {
		logic [NUM_CH-1:0][CH_W-1:0] ch;
		logic                        clipped;
		logic                        last;
	} sample_res_t;

	// a stimulus row: the beat, plus a hand-typed result where one is given
	typedef struct packed {
		beat_t       beat;
		logic        typed;
		sample_res_t res;
	} stim_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        out_stall = 1'b0;
	stim_row_t   in_row    = '0;
	logic        in_stall;
	logic        out_valid;
	logic signed [CH_W-1:0] res_ch0, res_ch1, res_ch2, res_ch3;
	logic        clipped, last_out;

	// private copy of the pixel store, updated at each accepted load beat
	logic [NUM_CH-1:0][CH_W-1:0] pixel_copy [SRC_DEPTH];

	// results still owed by the block, oldest first
	sample_res_t pending_samples [$];

	int mismatches   = 0;
	int results_seen = 0;
	int idle_cycles  = 0;
	int burst_left   = 0;
	logic hold_req   = 1'b0;

	bicubic_sample_four_channel_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (in_row.beat.op),
		.load_index (in_row.beat.load_index),
		.load_ch0   (in_row.beat.load_ch[0]),
		.load_ch1   (in_row.beat.load_ch[1]),
		.load_ch2   (in_row.beat.load_ch[2]),
		.load_ch3   (in_row.beat.load_ch[3]),
		.pos_a      (in_row.beat.pos[0]),
		.pos_b      (in_row.beat.pos[1]),
		.pos_c      (in_row.beat.pos[2]),
		.pos_d      (in_row.beat.pos[3]),
		.frac       (in_row.beat.frac),
		.last_in    (in_row.beat.last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res_ch0    (res_ch0),
		.res_ch1    (res_ch1),
		.res_ch2    (res_ch2),
		.res_ch3    (res_ch3),
		.clipped    (clipped),
		.last_out   (last_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin : reset_gen
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// keys cubic with a = -0.75 for one channel, exact
	// coefficients are kept times four, so the whole sum sits over 2^50:
	//   k3*t^3 + k2*t^2*2^16 + k1*t*2^32, with t the raw q0.16 fraction
	// adding 2^49 before the floor shift rounds half toward plus infinity
	function automatic void keys_channel(input int pa, input int pb, input int pc,
		input int pd, input int t, output logic [CH_W-1:0] val, output logic sat);
		logic signed [95:0] k3, k2, k1, tq, num, rounded;
		k3 = -3 * pa + 5 * pb - 5 * pc + 3 * pd;
		k2 = 6 * pa - 9 * pb + 6 * pc - 3 * pd;
		k1 = 3 * (pc - pa);
		tq = t;
		num = k3 * tq * tq * tq + ((k2 * tq * tq) <<< 16) + ((k1 * tq) <<< 32)
			+ (96'sd1 <<< 49);
		rounded = pb + (num >>> 50);
		sat = 1'b1;
		if (rounded > 32767) begin
			val = SAT_MAX;
		end else if (rounded < -32768) begin
			val = SAT_MIN;
		end else begin
			val = rounded[CH_W-1:0];
			sat = 1'b0;
		end
	endfunction

	// advance the private store by one accepted beat; a sample yields a result
	function automatic void step_sampler(input beat_t b, output logic has_res,
		output sample_res_t r);
		logic sat;
		r = '0;
		has_res = (b.op == OP_SAMPLE);
		if (b.op == OP_LOAD) begin
			pixel_copy[b.load_index] = b.load_ch;
		end else begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				keys_channel($signed(pixel_copy[b.pos[0]][ch]),
					$signed(pixel_copy[b.pos[1]][ch]),
					$signed(pixel_copy[b.pos[2]][ch]),
					$signed(pixel_copy[b.pos[3]][ch]),
					int'(b.frac), r.ch[ch], sat);
				r.clipped |= sat;
			end
			r.last = b.last;
		end
	endfunction

	function automatic stim_row_t load_row(input int idx, input int c0, input int c1,
		input int c2, input int c3);
		stim_row_t r;
		r = '0;
		r.beat.op = OP_LOAD;
		r.beat.load_index = IDX_W'(idx);
		r.beat.load_ch = {CH_W'(c3), CH_W'(c2), CH_W'(c1), CH_W'(c0)};
		return r;
	endfunction

	// typed rows carry one value for all four channels
	function automatic stim_row_t sample_row(input int a, input int b, input int c,
		input int d, input int t, input logic last, input logic typed,
		input int want, input logic clip);
		stim_row_t r;
		r = '0;
		r.beat.op = OP_SAMPLE;
		r.beat.pos = {IDX_W'(d), IDX_W'(c), IDX_W'(b), IDX_W'(a)};
		r.beat.frac = FRAC_W'(t);
		r.beat.last = last;
		r.typed = typed;
		r.res.ch = {NUM_CH{CH_W'(want)}};
		r.res.clipped = clip;
		r.res.last = last;
		return r;
	endfunction

	// channel level for random loads: rails and near-zero values come often
	function automatic logic [CH_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return SAT_MAX;
			1: return SAT_MIN;
			2: return CH_W'($urandom_range(0, 31) - 16);
			default: return CH_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("tb: result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	// offer one beat; bursts of random length with random gaps in between
	// valid only drops when a real gap follows, never low and high in one step
	task automatic send_row(input stim_row_t row);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_row <= row;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin : sender
		stim_row_t       directed [$];
		stim_row_t       row;
		logic [159:0]    noise;
		int              written [$];
		int              pick;

		wait (arst_n);
		@(posedge clk);

		// pixels: zero, both rails, mixed rails, and small values that land on
		// exact half-way points at t = 0.5 (positive and negative ties)
		directed.push_back(load_row(0, 0, 0, 0, 0));
		directed.push_back(load_row(1023, 32767, 32767, 32767, 32767));
		directed.push_back(load_row(1, -32768, -32768, -32768, -32768));
		directed.push_back(load_row(2, 32767, -32768, 0, -1));
		directed.push_back(load_row(4, 16, -16, 48, -48));
		directed.push_back(load_row(3, -32768, 32767, 1, 21845));

		// flat neighbourhoods give the base value at any fraction
		directed.push_back(sample_row(1023, 1023, 1023, 1023, 0, 1'b1, 1'b1, 32767, 1'b0));
		directed.push_back(sample_row(1, 1, 1, 1, 65535, 1'b0, 1'b1, -32768, 1'b0));
		directed.push_back(sample_row(0, 0, 0, 0, 32768, 1'b1, 1'b1, 0, 1'b0));
		// t = 0 returns b no matter what the other neighbours hold
		directed.push_back(sample_row(1, 1023, 1, 1, 0, 1'b0, 1'b1, 32767, 1'b0));
		// overshoot past either rail saturates and raises clipped
		directed.push_back(sample_row(1, 1023, 1023, 1, 32768, 1'b1, 1'b1, 32767, 1'b1));
		directed.push_back(sample_row(1023, 1, 1, 1023, 32768, 1'b0, 1'b1, -32768, 1'b1));
		// rounding ties, smallest and largest fractions, mixed neighbourhoods
		directed.push_back(sample_row(0, 0, 4, 0, 32768, 1'b1, 1'b0, 0, 1'b0));
		directed.push_back(sample_row(0, 2, 3, 1023, 1, 1'b0, 1'b0, 0, 1'b0));
		directed.push_back(sample_row(3, 2, 1, 0, 65535, 1'b1, 1'b0, 0, 1'b0));
		directed.push_back(sample_row(4, 3, 2, 1, 16384, 1'b0, 1'b0, 0, 1'b0));
		directed.push_back(sample_row(1023, 0, 1, 2, 49152, 1'b1, 1'b0, 0, 1'b0));

		foreach (directed[i]) begin
			if (directed[i].beat.op == OP_LOAD)
				written.push_back(int'(directed[i].beat.load_index));
			send_row(directed[i]);
		end

		// the receiver holds off for a long stretch while beats keep coming
		hold_req <= 1'b1;

		for (int n = 0; n < RAND_ITEMS; n++) begin
			noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
			row = '0;
			// fields that the operation ignores still carry random bits
			row.beat = noise[$bits(beat_t)-1:0];
			if ($urandom_range(0, 9) < 4) begin
				row.beat.op = OP_LOAD;
				for (int ch = 0; ch < NUM_CH; ch++)
					row.beat.load_ch[ch] = pick_level();
				written.push_back(int'(row.beat.load_index));
			end else begin
				row.beat.op = OP_SAMPLE;
				// neighbours only ever name entries that were loaded
				if ($urandom_range(0, 9) == 0) begin
					pick = written[$urandom_range(0, written.size() - 1)];
					row.beat.pos = {4{IDX_W'(pick)}};
				end else begin
					for (int k = 0; k < 4; k++)
						row.beat.pos[k] = IDX_W'(written[$urandom_range(0, written.size() - 1)]);
				end
				case ($urandom_range(0, 7))
					0: row.beat.frac = '0;
					1: row.beat.frac = '1;
					2: row.beat.frac = FRAC_W'(32768);
					default: row.beat.frac = FRAC_W'($urandom);
				endcase
			end
			send_row(row);
		end
		in_valid <= 1'b0;

		// drain, then give a late or extra result time to show up
		do @(posedge clk); while (pending_samples.size() != 0);
		repeat (4 * RESULT_LAT) @(posedge clk);
		if (mismatches == 0 && pending_samples.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// receiver: stretches of free flow, light and heavy random stall,
	// and once a long hold-off so that the block backs up into in_stall
	initial begin : receiver
		int   mode;
		int   span;
		logic held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 40);
			repeat (span) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= $urandom_range(0, 1);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ($urandom_range(0, 7) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// monitor: predict on every accepted input beat, check every accepted
	// result against the oldest expectation, and watch for lack of progress
	always @(posedge clk) begin : monitor
		sample_res_t want;
		sample_res_t got;
		logic        has_res;
		logic        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				step_sampler(in_row.beat, has_res, want);
				if (has_res)
					pending_samples.push_back(in_row.typed ? in_row.res : want);
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got = {res_ch3, res_ch2, res_ch1, res_ch0, clipped, last_out};
				if (pending_samples.size() == 0) begin
					report_mismatch("result with no sample outstanding");
				end else begin
					want = pending_samples.pop_front();
					for (int ch = 0; ch < NUM_CH; ch++) begin
						if (got.ch[ch] !== want.ch[ch])
							report_mismatch($sformatf("res_ch%0d got %0d want %0d", ch,
								$signed(got.ch[ch]), $signed(want.ch[ch])));
					end
					if (got.clipped !== want.clipped)
						report_mismatch($sformatf("clipped got %b want %b",
							got.clipped, want.clipped));
					if (got.last !== want.last)
						report_mismatch($sformatf("last_out got %b want %b",
							got.last, want.last));
				end
				results_seen++;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule
